[design/edc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package edc_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 22;

	localparam logic [YEAR_W-1:0]  YEAR_MAX        = 14'd9999;
	localparam logic [YEAR_W-1:0]  EPOCH_YEAR_RST  = 14'd1970;
	localparam logic [MONTH_W-1:0] EPOCH_MONTH_RST = 4'd1;
	localparam logic [DAY_W-1:0]   EPOCH_DAY_RST   = 5'd1;

	localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
	localparam logic [11:0] RECIP_25      = 12'd2622;
	localparam int          RECIP_SHIFT   = 16;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_TARGET_BAD = 2'd1,
		STATUS_BEFORE     = 2'd2,
		STATUS_EPOCH_BAD  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_EPOCH_YEAR  = 2'd0,
		CFG_EPOCH_MONTH = 2'd1,
		CFG_EPOCH_DAY   = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	typedef struct packed {
		logic               ok;
		logic [COUNT_W-1:0] num;
	} day_info_t;

	function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		unique case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] r;
		unique case (m)
			4'd2:                    r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default:                 r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[design/epoch_day_counter.sv]
`timescale 1ns / 1ps
`default_nettype none
// The strobe rises in the same cycle that the registered result appears on day_count and status.
// Throughput: one date per cycle; busy stays low, so every start is taken.
// The target passes an input register and a three stage day number unit, the epoch enters
// its own unit straight from the registers, and one compare and subtract stage follows.
// Reset clears the pipeline valid bits and the strobe and restores the epoch to 1970-01-01.
// The receiver cannot stall; each result is shown for exactly one cycle.

module epoch_day_counter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [edc_pkg::YEAR_W-1:0]  target_year,
	input  logic [edc_pkg::MONTH_W-1:0] target_month,
	input  logic [edc_pkg::DAY_W-1:0]   target_day,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [edc_pkg::YEAR_W-1:0]  cfg_wdata,
	output logic                        done,
	output logic [edc_pkg::COUNT_W-1:0] day_count,
	output logic [1:0]                  status
);
	import edc_pkg::*;

	date_t     epoch;
	date_t     target_s1;
	day_info_t target_info;
	day_info_t epoch_info;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;

	status_t            status_d;
	logic [COUNT_W-1:0] count_d;
	status_t            status_q;
	logic [COUNT_W-1:0] count_q;
	logic               done_q;

	edc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.epoch  (epoch)
	);

	assign busy = 1'b0;

	always_ff @(posedge clk) begin
		if (start) begin
			target_s1.year  <= target_year;
			target_s1.month <= target_month;
			target_s1.day   <= target_day;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	// The epoch goes through an identical unit straight from the registers, so its
	// day number lines up with a target taken just after a configuration write.
	edc_day_number u_target (
		.clk  (clk),
		.date (target_s1),
		.info (target_info)
	);

	edc_day_number u_epoch (
		.clk  (clk),
		.date (epoch),
		.info (epoch_info)
	);

	always_comb begin
		count_d = '0;
		priority if (!epoch_info.ok) begin
			status_d = STATUS_EPOCH_BAD;
		end else if (!target_info.ok) begin
			status_d = STATUS_TARGET_BAD;
		end else if (target_info.num < epoch_info.num) begin
			status_d = STATUS_BEFORE;
		end else begin
			status_d = STATUS_OK;
			count_d  = target_info.num - epoch_info.num;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			status_q <= status_d;
			count_q  <= count_d;
		end
	end

	assign done      = done_q;
	assign day_count = count_q;
	assign status    = status_q;

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 done)
		else $error("accepted date produced no result after five cycles");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result strobe without an accepted date");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STATUS_OK)) |-> (day_count == '0))
		else $error("nonzero day count with an error status");

	a_epoch_first: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !epoch_info.ok) |=> (status == STATUS_EPOCH_BAD))
		else $error("invalid epoch not reported");
`endif

endmodule

`default_nettype wire

[design/edc_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module edc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [1:0]                 index,
	input  logic [edc_pkg::YEAR_W-1:0] wdata,
	output edc_pkg::date_t             epoch
);
	import edc_pkg::*;

	date_t epoch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q.year  <= EPOCH_YEAR_RST;
			epoch_q.month <= EPOCH_MONTH_RST;
			epoch_q.day   <= EPOCH_DAY_RST;
		end else if (wr_en) begin
			unique case (index)
				CFG_EPOCH_YEAR:  epoch_q.year  <= wdata;
				CFG_EPOCH_MONTH: epoch_q.month <= wdata[MONTH_W-1:0];
				CFG_EPOCH_DAY:   epoch_q.day   <= wdata[DAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign epoch = epoch_q;

endmodule

`default_nettype wire

[design/edc_day_number.sv]
`timescale 1ns / 1ps
`default_nettype none

module edc_day_number (
	input  logic               clk,
	input  edc_pkg::date_t     date,
	output edc_pkg::day_info_t info
);
	import edc_pkg::*;

	logic [YEAR_W-1:0] p;

	logic [23:0]        p100_prod_s2;
	logic [23:0]        y100_prod_s2;
	logic [21:0]        p400_prod_s2;
	logic [21:0]        y400_prod_s2;
	logic [22:0]        p365_s2;
	logic [11:0]        p4_s2;
	logic [11:0]        y4_s2;
	logic [9:0]         y16_s2;
	logic [3:0]         ylo_s2;
	logic [MONTH_W-1:0] month_s2;
	logic [DAY_W-1:0]   day_s2;
	logic               year_ok_s2;
	logic               month_ok_s2;

	logic [7:0]  q_p100;
	logic [5:0]  q_p400;
	logic [7:0]  q_y100;
	logic [5:0]  q_y400;
	logic        div100;
	logic        div400;
	logic        leap;
	logic [22:0] year_days;

	logic [22:0]        year_days_s3;
	logic               leap_s3;
	logic [MONTH_W-1:0] month_s3;
	logic [DAY_W-1:0]   day_s3;
	logic               year_ok_s3;
	logic               month_ok_s3;

	logic [DAY_W-1:0] mlen;
	logic [22:0]      num;

	assign p = date.year - 14'd1;

	// Division by 100 and 400 is done as a division by 25 of the value shifted right,
	// using a reciprocal multiply that is exact over the year range.
	always_ff @(posedge clk) begin
		p100_prod_s2 <= 24'(p[13:2]) * 24'(RECIP_25);
		p400_prod_s2 <= 22'(p[13:4]) * 22'(RECIP_25);
		y100_prod_s2 <= 24'(date.year[13:2]) * 24'(RECIP_25);
		y400_prod_s2 <= 22'(date.year[13:4]) * 22'(RECIP_25);
		p365_s2      <= 23'(p) * 23'(DAYS_PER_YEAR);
		p4_s2        <= p[13:2];
		y4_s2        <= date.year[13:2];
		y16_s2       <= date.year[13:4];
		ylo_s2       <= date.year[3:0];
		month_s2     <= date.month;
		day_s2       <= date.day;
		year_ok_s2   <= (date.year != 14'd0) && (date.year <= YEAR_MAX);
		month_ok_s2  <= (date.month != 4'd0) && (date.month <= 4'd12);
	end

	always_comb begin
		q_p100    = p100_prod_s2[RECIP_SHIFT+7:RECIP_SHIFT];
		q_p400    = p400_prod_s2[RECIP_SHIFT+5:RECIP_SHIFT];
		q_y100    = y100_prod_s2[RECIP_SHIFT+7:RECIP_SHIFT];
		q_y400    = y400_prod_s2[RECIP_SHIFT+5:RECIP_SHIFT];
		div100    = (ylo_s2[1:0] == 2'd0) && (y4_s2 == 12'(q_y100) * 12'd25);
		div400    = (ylo_s2 == 4'd0) && (y16_s2 == 10'(q_y400) * 10'd25);
		leap      = (ylo_s2[1:0] == 2'd0) && (!div100 || div400);
		year_days = p365_s2 + 23'(p4_s2) - 23'(q_p100) + 23'(q_p400);
	end

	always_ff @(posedge clk) begin
		year_days_s3 <= year_days;
		leap_s3      <= leap;
		month_s3     <= month_s2;
		day_s3       <= day_s2;
		year_ok_s3   <= year_ok_s2;
		month_ok_s3  <= month_ok_s2;
	end

	always_comb begin
		mlen = month_length(month_s3, leap_s3);
		num  = year_days_s3 + 23'(days_before_month(month_s3))
			+ 23'(leap_s3 && (month_s3 > 4'd2)) + 23'(day_s3) - 23'd1;
	end

	always_ff @(posedge clk) begin
		info.ok  <= year_ok_s3 && month_ok_s3 && (day_s3 != 5'd0) && (day_s3 <= mlen);
		info.num <= num[COUNT_W-1:0];
	end

endmodule

`default_nettype wire

[tb/edc_checker.sv]
`timescale 1ns / 1ps

module edc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [edc_pkg::YEAR_W-1:0]  target_year,
	input  logic [edc_pkg::MONTH_W-1:0] target_month,
	input  logic [edc_pkg::DAY_W-1:0]   target_day,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [edc_pkg::YEAR_W-1:0]  cfg_wdata,
	input  logic                        done,
	input  logic [edc_pkg::COUNT_W-1:0] day_count,
	input  logic [1:0]                  status,
	output int                          fail_cnt,
	output int                          pending_cnt,
	output int                          results_seen,
	output int                          counted_seen
);

	import edc_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0] days;
		status_t            status;
	} conversion_t;

	conversion_t owed_counts[$];

	logic [YEAR_W-1:0]  ep_year;
	logic [MONTH_W-1:0] ep_month;
	logic [DAY_W-1:0]   ep_day;

	initial begin
		fail_cnt = 0;
		pending_cnt = 0;
		results_seen = 0;
		counted_seen = 0;
		ep_year = EPOCH_YEAR_RST;
		ep_month = EPOCH_MONTH_RST;
		ep_day = EPOCH_DAY_RST;
	end

	function automatic bit leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
		int unsigned len;
		case (m)
			2:           len = leap_year(y) ? 29 : 28;
			4, 6, 9, 11: len = 30;
			default:     len = 31;
		endcase
		return len;
	endfunction

	function automatic bit date_valid(input int unsigned y, input int unsigned m,
			input int unsigned d);
		if (y < 1 || y > YEAR_MAX) return 1'b0;
		if (m < 1 || m > 12) return 1'b0;
		return (d >= 1) && (d <= month_days(y, m));
	endfunction

	// Days elapsed since the first of January of year one.
	function automatic int unsigned day_serial(input int unsigned y, input int unsigned m,
			input int unsigned d);
		int unsigned p;
		int unsigned n;
		int unsigned k;
		p = y - 1;
		n = p * 365 + p / 4 - p / 100 + p / 400;
		for (k = 1; k < m; k++) n += month_days(y, k);
		return n + d - 1;
	endfunction

	function automatic conversion_t days_from_epoch(input int unsigned ey, input int unsigned em,
			input int unsigned ed, input int unsigned ty, input int unsigned tm,
			input int unsigned td);
		conversion_t r;
		int unsigned e;
		int unsigned t;
		r.days = '0;
		if (!date_valid(ey, em, ed)) begin
			r.status = STATUS_EPOCH_BAD;
		end else if (!date_valid(ty, tm, td)) begin
			r.status = STATUS_TARGET_BAD;
		end else begin
			e = day_serial(ey, em, ed);
			t = day_serial(ty, tm, td);
			if (t < e) begin
				r.status = STATUS_BEFORE;
			end else begin
				r.status = STATUS_OK;
				r.days = COUNT_W'(t - e);
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		fail_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		conversion_t want;
		if (!arst_n) begin
			ep_year = EPOCH_YEAR_RST;
			ep_month = EPOCH_MONTH_RST;
			ep_day = EPOCH_DAY_RST;
			owed_counts.delete();
		end else begin
			if (done) begin
				results_seen++;
				if (owed_counts.size() == 0) begin
					report_mismatch("result transfer with nothing pending", day_count, 0);
				end else begin
					want = owed_counts.pop_front();
					if (status != want.status)
						report_mismatch("status", status, want.status);
					if (day_count != want.days)
						report_mismatch("day_count", day_count, want.days);
					if (want.status == STATUS_OK) counted_seen++;
				end
			end
			if (start && !busy)
				owed_counts.push_back(days_from_epoch(ep_year, ep_month, ep_day,
					target_year, target_month, target_day));
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_EPOCH_YEAR:  ep_year = cfg_wdata;
					CFG_EPOCH_MONTH: ep_month = cfg_wdata[MONTH_W-1:0];
					CFG_EPOCH_DAY:   ep_day = cfg_wdata[DAY_W-1:0];
					default:         ;
				endcase
			end
		end
		pending_cnt = owed_counts.size();
	end

endmodule

[tb/epoch_day_counter_tb.sv]
`timescale 1ns / 1ps

module epoch_day_counter_tb;

	import edc_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int DUT_LATENCY = 5;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PHASES = 22;
	localparam int DATES_PER_PHASE = 50;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [YEAR_W-1:0]   target_year = '0;
	logic [MONTH_W-1:0]  target_month = '0;
	logic [DAY_W-1:0]    target_day = '0;
	logic                cfg_wr_en = 1'b0;
	logic [1:0]          cfg_index = '0;
	logic [YEAR_W-1:0]   cfg_wdata = '0;
	logic                busy;
	logic                done;
	logic [COUNT_W-1:0]  day_count;
	logic [1:0]          status;

	int fail_cnt;
	int pending_cnt;
	int results_seen;
	int counted_seen;
	int cycles = 0;
	int sent = 0;
	int epoch_settings = 1;
	int epoch_year_now = 1970;
	bit gaps_on = 1'b1;

	epoch_day_counter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.target_year  (target_year),
		.target_month (target_month),
		.target_day   (target_day),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.day_count    (day_count),
		.status       (status)
	);

	edc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.target_year  (target_year),
		.target_month (target_month),
		.target_day   (target_day),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.day_count    (day_count),
		.status       (status),
		.fail_cnt     (fail_cnt),
		.pending_cnt  (pending_cnt),
		.results_seen (results_seen),
		.counted_seen (counted_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int clamp_year(input int y);
		if (y < 1) return 1;
		if (y > 9999) return 9999;
		return y;
	endfunction

	task automatic send_date(input int y, input int m, input int d);
		start <= 1'b1;
		target_year <= y[YEAR_W-1:0];
		target_month <= m[MONTH_W-1:0];
		target_day <= d[DAY_W-1:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	task automatic maybe_gap();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			target_year <= YEAR_W'($urandom);
			target_month <= MONTH_W'($urandom);
			target_day <= DAY_W'($urandom);
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (pending_cnt != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input int data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data[YEAR_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_epoch(input int y, input int m, input int d);
		settle();
		cfg_write(CFG_EPOCH_YEAR, y);
		cfg_write(CFG_EPOCH_MONTH, m);
		cfg_write(CFG_EPOCH_DAY, d);
		cfg_wr_en <= 1'b0;
		epoch_settings++;
		epoch_year_now = y;
	endtask

	// Month and day writes carry random upper bits that the registers must drop.
	task automatic random_epoch();
		int y;
		int m;
		int d;
		int first;
		int k;
		y = $urandom_range(1, 9999);
		m = $urandom_range(1, 12);
		d = $urandom_range(1, 28);
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: y = $urandom_range(0, 1) ? 0 : $urandom_range(10000, 16383);
					1: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
					2: d = 0;
					3: begin
						m = 2;
						d = $urandom_range(30, 31);
					end
					default: begin
						m = 4;
						d = 31;
					end
				endcase
			end
			1: begin
				case ($urandom_range(0, 2))
					0: begin
						y = 1;
						m = 1;
						d = 1;
					end
					1: begin
						y = 9999;
						m = 12;
						d = 31;
					end
					default: begin
						y = 4 * $urandom_range(1, 2499);
						m = 2;
						d = 29;
					end
				endcase
			end
			default: ;
		endcase
		settle();
		first = $urandom_range(0, 2);
		for (k = 0; k < 3; k++) begin
			case ((first + k) % 3)
				0: cfg_write(CFG_EPOCH_YEAR, y);
				1: cfg_write(CFG_EPOCH_MONTH, ($urandom_range(0, 1023) << 4) | m);
				default: cfg_write(CFG_EPOCH_DAY, ($urandom_range(0, 511) << 5) | d);
			endcase
		end
		if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, $urandom);
		cfg_wr_en <= 1'b0;
		epoch_settings++;
		epoch_year_now = y;
	endtask

	task automatic random_date();
		int y;
		int m;
		int d;
		m = $urandom_range(1, 12);
		d = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
		if ($urandom_range(0, 1) == 0)
			y = clamp_year(epoch_year_now + $urandom_range(0, 80) - 5);
		else
			y = $urandom_range(1, 9999);
		case ($urandom_range(0, 9))
			0, 1: begin
				y = $urandom_range(0, 16383);
				m = $urandom_range(0, 15);
				d = $urandom_range(0, 31);
			end
			2: begin
				y = $urandom_range(0, 1) ? 100 * $urandom_range(1, 99) : 4 * $urandom_range(1, 2499);
				m = 2;
				d = $urandom_range(28, 30);
			end
			default: ;
		endcase
		send_date(y, m, d);
	endtask

	initial begin
		int p;
		int i;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_date(1970, 1, 1);
		send_date(9999, 12, 31);
		send_date(1969, 12, 31);
		send_date(1, 1, 1);
		send_date(0, 1, 1);
		send_date(16383, 15, 31);
		send_date(10000, 1, 1);
		send_date(2021, 0, 10);
		send_date(2021, 13, 10);
		send_date(2021, 15, 10);
		send_date(2021, 5, 0);
		send_date(2021, 4, 31);
		send_date(2021, 1, 31);
		send_date(2000, 2, 29);
		send_date(1900, 2, 29);
		maybe_gap();
		send_date(2024, 2, 29);
		send_date(2023, 2, 29);
		send_date(2023, 2, 28);
		send_date(1969, 13, 1);
		send_date(0, 0, 0);

		set_epoch(1, 1, 1);
		send_date(1, 1, 1);
		send_date(9999, 12, 31);
		send_date(0, 1, 1);
		send_date(1, 2, 29);
		send_date(400, 2, 29);

		set_epoch(9999, 12, 31);
		send_date(9999, 12, 31);
		send_date(9999, 12, 30);
		send_date(1, 1, 1);
		send_date(16383, 15, 31);

		set_epoch(2000, 2, 29);
		send_date(2000, 2, 29);
		send_date(2000, 3, 1);
		send_date(2000, 2, 28);

		set_epoch(1900, 2, 29);
		send_date(1970, 1, 1);
		send_date(0, 0, 0);

		set_epoch(0, 1, 1);
		send_date(2000, 1, 1);

		// Data with all upper bits set: year out of range, month thirteen, day zero.
		set_epoch(16383, 16'h3FFD, 16'h3FE0);
		send_date(2000, 1, 1);

		set_epoch(1970, 16'h3FF1, 16'h3FE1);
		settle();
		cfg_write(CFG_SPARE, 16'h3FFF);
		cfg_write(CFG_SPARE, 0);
		cfg_wr_en <= 1'b0;
		send_date(1970, 1, 1);
		send_date(2038, 1, 19);

		for (p = 0; p < RANDOM_PHASES; p++) begin
			random_epoch();
			gaps_on = (p < RANDOM_PHASES - 3) && ($urandom_range(0, 3) != 0);
			for (i = 0; i < DATES_PER_PHASE; i++) begin
				maybe_gap();
				random_date();
			end
		end

		settle();
		repeat (DUT_LATENCY * 4) @(posedge clk);
		$display("Converted %0d dates under %0d epoch settings, valid and invalid.",
			sent, epoch_settings);
		$display("Checked %0d results, %0d of them with a day count.",
			results_seen, counted_seen);
		if (fail_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
